// ===== hw/rtl/ppcc_pkg.sv =====
`timescale 1ns / 1ps

package ppcc_pkg;

    localparam int BARCODE_LEN = 4;
    localparam int UMI_LEN     = 8;
    localparam int COUNT_WIDTH = 32;

    localparam int CHAR_W       = 8;
    localparam int OUT_CNT_W    = 32;
    localparam int VOTE_FLOOR_W = 3;
    localparam int PFX_W        = $clog2(UMI_LEN + 2);
    localparam int VOTE_W       = $clog2(BARCODE_LEN + 1);
    localparam int CMP_W        = (VOTE_W > VOTE_FLOOR_W) ? VOTE_W : VOTE_FLOOR_W;
    localparam int NUM_CNT      = 4;

    localparam logic [VOTE_FLOOR_W-1:0] VOTE_FLOOR_RESET = VOTE_FLOOR_W'(3);

    localparam logic [CHAR_W-1:0] CHR_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CHR_G     = 8'h47;
    localparam logic [CHAR_W-1:0] CHR_T     = 8'h54;
    localparam logic [CHAR_W-1:0] CHR_C     = 8'h43;
    localparam logic [CHAR_W-1:0] CHR_N     = 8'h4E;
    localparam logic [CHAR_W-1:0] CHR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHR_NUL   = 8'h00;

    localparam logic [1:0] CH_UNBOUND = 2'd0;
    localparam logic [1:0] CH_BOUND   = 2'd1;
    localparam logic [1:0] CH_NONE    = 2'd2;

    localparam logic [1:0] KIND_FULL  = 2'd0;
    localparam logic [1:0] KIND_PART  = 2'd1;
    localparam logic [1:0] KIND_NONE  = 2'd2;

    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_NO_SPACE = 2'd1;
    localparam logic [1:0] ERR_SHORT    = 2'd2;
    localparam logic [1:0] ERR_BAD_BASE = 2'd3;

    localparam int CNT_UNB_FULL = 0;
    localparam int CNT_UNB_PART = 1;
    localparam int CNT_BND_FULL = 2;
    localparam int CNT_BND_PART = 3;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              end_of_line;
    } char_item_t;

    typedef struct packed {
        logic [1:0]           channel;
        logic [1:0]           match_kind;
        logic [1:0]           error_code;
        logic [OUT_CNT_W-1:0] unbound_full_count;
        logic [OUT_CNT_W-1:0] unbound_part_count;
        logic [OUT_CNT_W-1:0] bound_full_count;
        logic [OUT_CNT_W-1:0] bound_part_count;
    } result_item_t;

endpackage

// ===== hw/rtl/purine_pyrimidine_channel_classifier.sv =====
`timescale 1ns / 1ps

// Classifies read-identifier lines, one character per transfer on the char channel, by the
// purine/pyrimidine pattern of the barcode that sits UMI_LEN characters before the first
// space. One character is taken every clock cycle while char_ready is high; the line state is
// updated as each character is taken and the four saturating match counters as a line's last
// character is taken; the line's result is registered in the output entry or the skid entry.
// A two-entry output buffer lets the char channel keep running while one result waits on
// the result channel; char_ready drops only when both entries are full. The vote floor may
// be written through the cfg channel at any time the block is idle and is always ready.
module purine_pyrimidine_channel_classifier (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ppcc_pkg::VOTE_FLOOR_W-1:0] cfg_data,
    input  logic                        char_valid,
    output logic                        char_ready,
    input  ppcc_pkg::char_item_t        char_data,
    output logic                        result_valid,
    input  logic                        result_ready,
    output ppcc_pkg::result_item_t      result_data
);
    import ppcc_pkg::*;

    logic [VOTE_FLOOR_W-1:0] vote_floor_reg;
    logic [CHAR_W-1:0]      recent_reg [UMI_LEN];
    logic [CHAR_W-1:0]      recent_next [UMI_LEN];
    logic [PFX_W-1:0]       prefix_reg;
    logic [PFX_W-1:0]       prefix_next;
    logic                   space_seen_reg;
    logic                   space_seen_next;
    logic                   line_ended_reg;
    logic                   line_ended_next;
    logic [COUNT_WIDTH-1:0] cnt_reg [NUM_CNT];
    logic [COUNT_WIDTH-1:0] cnt_next [NUM_CNT];

    result_item_t           out_reg;
    result_item_t           out_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    result_item_t           skid_reg;
    result_item_t           skid_next;
    logic                   skid_valid_reg;
    logic                   skid_valid_next;

    logic                   take;
    logic                   produce;
    logic                   out_free;
    result_item_t           new_result;
    logic [CHAR_W-1:0]      base;
    logic [VOTE_W-1:0]      unb_votes;
    logic [VOTE_W-1:0]      bnd_votes;
    logic                   bad_base;
    logic [1:0]             err;
    logic [CMP_W-1:0]       unb_cmp;
    logic [CMP_W-1:0]       bnd_cmp;
    logic [CMP_W-1:0]       floor_cmp;

    assign cfg_ready    = 1'b1;
    assign char_ready   = !skid_valid_reg;
    assign take         = char_valid && char_ready;
    assign produce      = take && char_data.end_of_line;
    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;
    assign out_free     = !out_valid_reg || result_ready;

    // Line state as it stands after the current character.
    always_comb
    begin
        recent_next     = recent_reg;
        prefix_next     = prefix_reg;
        space_seen_next = space_seen_reg;
        line_ended_next = line_ended_reg;
        if (!space_seen_reg && !line_ended_reg)
        begin
            if (char_data.character == CHR_NUL)
            begin
                line_ended_next = 1'b1;
            end
            else if (char_data.character == CHR_SPACE)
            begin
                space_seen_next = 1'b1;
            end
            else
            begin
                for (int i = 0; i < UMI_LEN - 1; i++)
                begin
                    recent_next[i] = recent_reg[i+1];
                end
                recent_next[UMI_LEN-1] = char_data.character;
                if (prefix_reg <= PFX_W'(UMI_LEN))
                begin
                    prefix_next = prefix_reg + PFX_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        unb_votes = '0;
        bnd_votes = '0;
        bad_base  = 1'b0;
        base      = CHR_SPACE;
        for (int k = 0; k < BARCODE_LEN; k++)
        begin
            base = (k < UMI_LEN) ? recent_next[k % UMI_LEN] : CHR_SPACE;
            if (base == CHR_A || base == CHR_G)
            begin
                if (k == 0)
                begin
                    bnd_votes = bnd_votes + VOTE_W'(1);
                end
                else
                begin
                    unb_votes = unb_votes + VOTE_W'(1);
                end
            end
            else if (base == CHR_T || base == CHR_C)
            begin
                if (k == 0)
                begin
                    unb_votes = unb_votes + VOTE_W'(1);
                end
                else
                begin
                    bnd_votes = bnd_votes + VOTE_W'(1);
                end
            end
            else if (base != CHR_N)
            begin
                bad_base = 1'b1;
            end
        end
    end

    assign unb_cmp   = CMP_W'(unb_votes);
    assign bnd_cmp   = CMP_W'(bnd_votes);
    assign floor_cmp = CMP_W'(vote_floor_reg);

    always_comb
    begin
        priority if (!space_seen_next)
        begin
            err = ERR_NO_SPACE;
        end
        else if (prefix_next <= PFX_W'(UMI_LEN))
        begin
            err = ERR_SHORT;
        end
        else if (bad_base)
        begin
            err = ERR_BAD_BASE;
        end
        else
        begin
            err = ERR_OK;
        end
    end

    always_comb
    begin
        cnt_next              = cnt_reg;
        new_result            = '0;
        new_result.channel    = CH_NONE;
        new_result.match_kind = KIND_NONE;
        new_result.error_code = err;
        if (err == ERR_OK)
        begin
            priority if (unb_cmp >= floor_cmp)
            begin
                new_result.channel = CH_UNBOUND;
                if (unb_votes == VOTE_W'(BARCODE_LEN))
                begin
                    new_result.match_kind = KIND_FULL;
                    if (cnt_reg[CNT_UNB_FULL] != '1)
                    begin
                        cnt_next[CNT_UNB_FULL] = cnt_reg[CNT_UNB_FULL] + COUNT_WIDTH'(1);
                    end
                end
                else
                begin
                    new_result.match_kind = KIND_PART;
                    if (cnt_reg[CNT_UNB_PART] != '1)
                    begin
                        cnt_next[CNT_UNB_PART] = cnt_reg[CNT_UNB_PART] + COUNT_WIDTH'(1);
                    end
                end
            end
            else if (bnd_cmp >= floor_cmp)
            begin
                new_result.channel = CH_BOUND;
                if (bnd_votes == VOTE_W'(BARCODE_LEN))
                begin
                    new_result.match_kind = KIND_FULL;
                    if (cnt_reg[CNT_BND_FULL] != '1)
                    begin
                        cnt_next[CNT_BND_FULL] = cnt_reg[CNT_BND_FULL] + COUNT_WIDTH'(1);
                    end
                end
                else
                begin
                    new_result.match_kind = KIND_PART;
                    if (cnt_reg[CNT_BND_PART] != '1)
                    begin
                        cnt_next[CNT_BND_PART] = cnt_reg[CNT_BND_PART] + COUNT_WIDTH'(1);
                    end
                end
            end
            else
            begin
                new_result.channel = CH_NONE;
            end
        end
        new_result.unbound_full_count = OUT_CNT_W'(cnt_next[CNT_UNB_FULL]);
        new_result.unbound_part_count = OUT_CNT_W'(cnt_next[CNT_UNB_PART]);
        new_result.bound_full_count   = OUT_CNT_W'(cnt_next[CNT_BND_FULL]);
        new_result.bound_part_count   = OUT_CNT_W'(cnt_next[CNT_BND_PART]);
    end

    // The skid entry always holds the younger of the two buffered results.
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_next       = new_result;
                skid_valid_next = produce;
            end
            else
            begin
                out_next       = new_result;
                out_valid_next = produce;
            end
        end
        else if (produce)
        begin
            skid_next       = new_result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vote_floor_reg <= VOTE_FLOOR_RESET;
            prefix_reg     <= '0;
            space_seen_reg <= 1'b0;
            line_ended_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CNT; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                vote_floor_reg <= cfg_data;
            end
            if (take)
            begin
                if (char_data.end_of_line)
                begin
                    prefix_reg     <= '0;
                    space_seen_reg <= 1'b0;
                    line_ended_reg <= 1'b0;
                    cnt_reg        <= cnt_next;
                end
                else
                begin
                    prefix_reg     <= prefix_next;
                    space_seen_reg <= space_seen_next;
                    line_ended_reg <= line_ended_next;
                end
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Characters kept before a space are only read once the prefix has filled them all.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            recent_reg <= recent_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid entry is full while the output entry is empty.");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.error_code != ERR_OK |->
            result_data.channel == CH_NONE && result_data.match_kind == KIND_NONE)
        else $error("A line with an error reports a channel or a match.");

    assert property (@(posedge clk) disable iff (!rst_n)
        take && !char_data.end_of_line |=>
            $stable(cnt_reg[CNT_UNB_FULL]) && $stable(cnt_reg[CNT_UNB_PART]) &&
            $stable(cnt_reg[CNT_BND_FULL]) && $stable(cnt_reg[CNT_BND_PART]))
        else $error("A match counter changed inside a line.");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import ppcc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_PAUSE = 4;
    localparam int HOLD_CYCLES = 80;

    typedef enum int {LEAN_UNBOUND, LEAN_BOUND, LEAN_ANY} barcode_lean_t;

    class verdict_ledger;
        logic [CHAR_W-1:0]       recent [UMI_LEN];
        int                      prefix_len;
        bit                      space_seen;
        bit                      line_ended;
        logic [COUNT_WIDTH-1:0]  counts [NUM_CNT];
        logic [VOTE_FLOOR_W-1:0] vote_floor;
        result_item_t            expected_q [$];
        int                      errors;

        function new();
            clear_line();
            foreach (counts[i])
            begin
                counts[i] = '0;
            end
            vote_floor = VOTE_FLOOR_RESET;
            errors = 0;
        endfunction

        function void clear_line();
            foreach (recent[i])
            begin
                recent[i] = '0;
            end
            prefix_len = 0;
            space_seen = 1'b0;
            line_ended = 1'b0;
        endfunction

        function void set_vote_floor(logic [VOTE_FLOOR_W-1:0] value);
            vote_floor = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void bump(int idx);
            if (counts[idx] != '1)
            begin
                counts[idx] = counts[idx] + 1'b1;
            end
        endfunction

        function void take_char(char_item_t item);
            result_item_t      r;
            int                unb;
            int                bnd;
            int                k;
            logic [CHAR_W-1:0] b;
            logic [1:0]        err;
            if (!space_seen && !line_ended)
            begin
                if (item.character == CHR_NUL)
                begin
                    line_ended = 1'b1;
                end
                else if (item.character == CHR_SPACE)
                begin
                    space_seen = 1'b1;
                end
                else
                begin
                    for (k = 0; k < UMI_LEN - 1; k++)
                    begin
                        recent[k] = recent[k + 1];
                    end
                    recent[UMI_LEN - 1] = item.character;
                    if (prefix_len <= UMI_LEN)
                    begin
                        prefix_len++;
                    end
                end
            end
            if (!item.end_of_line)
            begin
                return;
            end
            unb = 0;
            bnd = 0;
            err = ERR_OK;
            if (!space_seen)
            begin
                err = ERR_NO_SPACE;
            end
            else if (prefix_len <= UMI_LEN)
            begin
                err = ERR_SHORT;
            end
            else
            begin
                for (k = 0; k < BARCODE_LEN; k++)
                begin
                    b = (k < UMI_LEN) ? recent[k] : CHR_SPACE;
                    if (b == CHR_A || b == CHR_G)
                    begin
                        if (k == 0) bnd++;
                        else unb++;
                    end
                    else if (b == CHR_T || b == CHR_C)
                    begin
                        if (k == 0) unb++;
                        else bnd++;
                    end
                    else if (b != CHR_N)
                    begin
                        err = ERR_BAD_BASE;
                    end
                end
            end
            r.channel = CH_NONE;
            r.match_kind = KIND_NONE;
            if (err == ERR_OK)
            begin
                if (unb >= int'(vote_floor))
                begin
                    r.channel = CH_UNBOUND;
                    r.match_kind = (unb == BARCODE_LEN) ? KIND_FULL : KIND_PART;
                    bump((unb == BARCODE_LEN) ? CNT_UNB_FULL : CNT_UNB_PART);
                end
                else if (bnd >= int'(vote_floor))
                begin
                    r.channel = CH_BOUND;
                    r.match_kind = (bnd == BARCODE_LEN) ? KIND_FULL : KIND_PART;
                    bump((bnd == BARCODE_LEN) ? CNT_BND_FULL : CNT_BND_PART);
                end
            end
            r.error_code = err;
            r.unbound_full_count = OUT_CNT_W'(counts[CNT_UNB_FULL]);
            r.unbound_part_count = OUT_CNT_W'(counts[CNT_UNB_PART]);
            r.bound_full_count = OUT_CNT_W'(counts[CNT_BND_FULL]);
            r.bound_part_count = OUT_CNT_W'(counts[CNT_BND_PART]);
            expected_q.push_back(r);
            clear_line();
        endfunction

        function void compare_field(string name, logic [OUT_CNT_W-1:0] want,
                                    logic [OUT_CNT_W-1:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_verdict(result_item_t got);
            result_item_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result transfer with none expected, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("channel", OUT_CNT_W'(want.channel), OUT_CNT_W'(got.channel));
            compare_field("match_kind", OUT_CNT_W'(want.match_kind),
                          OUT_CNT_W'(got.match_kind));
            compare_field("error_code", OUT_CNT_W'(want.error_code),
                          OUT_CNT_W'(got.error_code));
            compare_field("unbound_full_count", want.unbound_full_count,
                          got.unbound_full_count);
            compare_field("unbound_part_count", want.unbound_part_count,
                          got.unbound_part_count);
            compare_field("bound_full_count", want.bound_full_count, got.bound_full_count);
            compare_field("bound_part_count", want.bound_part_count, got.bound_part_count);
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [VOTE_FLOOR_W-1:0] cfg_data;
    logic                    char_valid;
    logic                    char_ready;
    char_item_t              char_data;
    logic                    result_valid;
    logic                    result_ready;
    result_item_t            result_data;

    verdict_ledger     verdicts = new();
    logic [CHAR_W-1:0] line_buf [$];
    int                chars_sent;
    int                cycle_count = 0;
    int                hold_left;
    bit                steady;
    bit                hold_request;

    purine_pyrimidine_channel_classifier u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_data    (char_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("purine_pyrimidine_channel_classifier regression: fail");
            $finish;
        end
    end

    initial
    begin
        result_ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
            begin
                verdicts.check_verdict(result_data);
            end
            if (hold_left > 0)
            begin
                result_ready <= 1'b0;
                hold_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= steady || ($urandom_range(0, 99) >= 9);
            end
        end
    end

    function automatic logic [CHAR_W-1:0] filler_char();
        logic [CHAR_W-1:0] c;
        do
        begin
            c = CHAR_W'($urandom_range(1, 255));
        end
        while (c == CHR_SPACE);
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] any_base();
        case ($urandom_range(0, 4))
            0: return CHR_A;
            1: return CHR_G;
            2: return CHR_T;
            3: return CHR_C;
            default: return CHR_N;
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] noise_char();
        case ($urandom_range(0, 3))
            0: return CHR_NUL;
            1: return CHR_SPACE;
            2: return any_base();
            default: return CHAR_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] barcode_base(int pos, barcode_lean_t lean);
        bit want_purine;
        if ($urandom_range(0, 19) == 0)
        begin
            return filler_char();
        end
        if (lean == LEAN_ANY || $urandom_range(0, 3) == 0)
        begin
            return any_base();
        end
        want_purine = (pos == 0) ? (lean == LEAN_BOUND) : (lean == LEAN_UNBOUND);
        if (want_purine)
        begin
            return $urandom_range(0, 1) ? CHR_A : CHR_G;
        end
        return $urandom_range(0, 1) ? CHR_T : CHR_C;
    endfunction

    task automatic send_char(char_item_t item);
        if (!steady && $urandom_range(0, 99) < 9)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_data <= item;
        do
        begin
            @(posedge clk);
        end
        while (!char_ready);
        verdicts.take_char(item);
        chars_sent++;
    endtask

    task automatic send_line();
        char_item_t item;
        int         k;
        for (k = 0; k < line_buf.size(); k++)
        begin
            item.character = line_buf[k];
            item.end_of_line = (k == line_buf.size() - 1);
            send_char(item);
        end
        line_buf.delete();
    endtask

    task automatic queue_text(string s);
        int k;
        for (k = 0; k < s.len(); k++)
        begin
            line_buf.push_back(s[k]);
        end
    endtask

    task automatic wait_results_drained();
        char_valid <= 1'b0;
        while (verdicts.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    task automatic write_vote_floor(logic [VOTE_FLOOR_W-1:0] value);
        wait_results_drained();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        verdicts.set_vote_floor(value);
    endtask

    task automatic random_line();
        int            len;
        int            k;
        int            tail_len;
        barcode_lean_t lean;
        if ($urandom_range(0, 99) < 78)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 24) : $urandom_range(9, 12);
            lean = barcode_lean_t'($urandom_range(0, 2));
            for (k = 0; k < len; k++)
            begin
                if (k >= len - UMI_LEN && k < len - UMI_LEN + BARCODE_LEN)
                begin
                    line_buf.push_back(barcode_base(k - (len - UMI_LEN), lean));
                end
                else
                begin
                    line_buf.push_back(filler_char());
                end
            end
            line_buf.push_back(CHR_SPACE);
            tail_len = $urandom_range(0, 4);
            for (k = 0; k < tail_len; k++)
            begin
                line_buf.push_back(CHAR_W'($urandom_range(0, 255)));
            end
        end
        else
        begin
            len = $urandom_range(1, 12);
            for (k = 0; k < len; k++)
            begin
                line_buf.push_back(noise_char());
            end
        end
        send_line();
    endtask

    task automatic random_lines_until(int target);
        while (chars_sent < target)
        begin
            random_line();
        end
    endtask

    initial
    begin
        int k;
        int n;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        char_valid = 1'b0;
        char_data = '0;
        steady = 1'b0;
        hold_request = 1'b0;
        chars_sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        queue_text("QCAGA1234 ");
        send_line();
        queue_text("QATCT1234 ");
        send_line();
        queue_text("QCAGN1234 x");
        send_line();
        queue_text("QANCT1234 ");
        send_line();
        queue_text("QCATN1234 ");
        send_line();
        queue_text("QCAxA1234 ");
        send_line();
        queue_text("abc");
        send_line();
        queue_text(" ");
        send_line();
        queue_text("12345678 ");
        send_line();
        queue_text("Q");
        line_buf.push_back(CHR_NUL);
        queue_text(" CAGA");
        send_line();
        line_buf.push_back(CHR_NUL);
        send_line();
        queue_text("0123456789abCAGA1234 A ");
        line_buf.push_back(CHR_NUL);
        queue_text("T");
        send_line();

        write_vote_floor(3'd0);
        queue_text("QNNNN1234 ");
        send_line();
        queue_text("QCAxA1234 ");
        send_line();
        random_lines_until(250);

        write_vote_floor(3'd4);
        random_lines_until(400);

        write_vote_floor(3'd7);
        random_lines_until(480);

        write_vote_floor(VOTE_FLOOR_W'($urandom_range(5, 6)));
        random_lines_until(540);

        write_vote_floor(3'd2);
        hold_request = 1'b1;
        for (n = 0; n < 40; n++)
        begin
            for (k = $urandom_range(1, 3); k > 0; k--)
            begin
                line_buf.push_back(noise_char());
            end
            send_line();
        end
        wait_results_drained();
        random_lines_until(720);

        write_vote_floor(3'd1);
        steady = 1'b1;
        random_lines_until(880);
        steady = 1'b0;

        write_vote_floor(3'd3);
        random_lines_until(940);

        wait_results_drained();
        repeat (16) @(posedge clk);
        if (verdicts.errors == 0 && verdicts.pending() == 0)
        begin
            $display("purine_pyrimidine_channel_classifier regression: pass");
        end
        else
        begin
            $display("purine_pyrimidine_channel_classifier regression: fail");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/ppcc_pkg.sv
hw/rtl/purine_pyrimidine_channel_classifier.sv
verif/tb.sv
